>>> rtl/edb_pkg.sv
// ============================================================================
// Expression DAG builder package
// Shared sizes, codes and the command and status groups between the
// controller and the datapath of the expression DAG builder.
// ============================================================================
package edb_pkg;

   // Storage sizes.
   localparam int TABLE_DEPTH = 128;
   localparam int STACK_DEPTH = 64;

   // Derived widths.
   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int SIDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SDEP_W    = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_W    = 8;
   localparam int NODE_ID_W = 7;
   localparam int ERR_W     = 2;

   // Characters with a fixed meaning.
   localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

   // Error codes on the result word.
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE           = 2'd0,
      ERR_TABLE_FULL     = 2'd1,
      ERR_STACK_OVERFLOW = 2'd2,
      ERR_AFTER_DONE     = 2'd3
   } err_type;

   // What an open frame waits for next.
   typedef enum logic [1:0] {
      PH_LEFT  = 2'd0,
      PH_OPER  = 2'd1,
      PH_RIGHT = 2'd2,
      PH_CLOSE = 2'd3
   } phase_type;

   // One entry of the frame stack.
   typedef struct packed {
      logic [IDX_W-1:0]  left;
      logic [CHAR_W-1:0] oper;
      phase_type         phase;
   } frame_type;

   // One node key of the value-numbering table.
   typedef struct packed {
      logic              leaf;
      logic [CHAR_W-1:0] oper;
      logic [IDX_W-1:0]  left;
      logic [IDX_W-1:0]  right;
      logic [CHAR_W-1:0] chr;
   } key_type;

   // How the current character is handled.
   typedef enum logic [1:0] {
      DEC_OPER  = 2'd0,
      DEC_CLOSE = 2'd1,
      DEC_OPEN  = 2'd2,
      DEC_LEAF  = 2'd3
   } dec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic frame_read;
      logic decide;
      logic scan;
      logic link;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic after_done;
      logic lookup;
      logic hit;
      logic miss;
      logic full;
      logic rsp_busy;
   } status_type;

endpackage

>>> rtl/edb_ctrl.sv
// ============================================================================
// Expression DAG builder controller
// Sequences one input word through frame fetch, decode, and for a lookup a table
// scan and frame update, then result hand-off, by issuing commands to the datapath.
// ============================================================================
module edb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  edb_pkg::status_type status,
   output edb_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DECIDE,
      ST_SCAN,
      ST_LINK_RD,
      ST_LINK,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // A new word is taken only between items.
   assign req_ready = (state_ff == ST_IDLE);

   // Commands follow from the state, gated by the request and result handshakes.
   always_comb begin
      cmd            = '0;
      cmd.accept     = (state_ff == ST_IDLE) && req_valid;
      cmd.frame_read = (state_ff == ST_FETCH) || (state_ff == ST_LINK_RD);
      cmd.decide     = (state_ff == ST_DECIDE);
      cmd.scan       = (state_ff == ST_SCAN);
      cmd.link       = (state_ff == ST_LINK);
      cmd.emit       = (state_ff == ST_EMIT) && !status.rsp_busy;
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= status.after_done ? ST_EMIT : ST_FETCH;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               state_ff <= status.lookup ? ST_SCAN : ST_EMIT;
            end
            ST_SCAN: begin
               if (status.hit) begin
                  state_ff <= ST_LINK_RD;
               end else if (status.miss) begin
                  state_ff <= status.full ? ST_EMIT : ST_LINK_RD;
               end
            end
            ST_LINK_RD: begin
               state_ff <= ST_LINK;
            end
            ST_LINK: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!status.rsp_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

>>> rtl/edb_datapath.sv
// ============================================================================
// Expression DAG builder datapath
// Holds the node key table, the frame stack, the scan pipeline and the
// result register, and acts on the controller's commands.
// ============================================================================
module edb_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  edb_pkg::cmd_type                     cmd,
   output edb_pkg::status_type                  status,
   input  logic [edb_pkg::CHAR_W-1:0]           req_ch,
   input  logic                                 req_start_expr,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_node_valid,
   output logic [edb_pkg::NODE_ID_W-1:0]        rsp_node_id,
   output logic                                 rsp_node_new,
   output logic                                 rsp_root_done,
   output logic [edb_pkg::ERR_W-1:0]            rsp_error_code
);

   // Storage.
   edb_pkg::key_type                 key_mem [edb_pkg::TABLE_DEPTH];
   edb_pkg::frame_type               frame_mem [edb_pkg::STACK_DEPTH];

   // Control state.
   logic [edb_pkg::CNT_W-1:0]        count_ff;
   logic [edb_pkg::SDEP_W-1:0]       depth_ff;
   logic                             done_ff;
   logic [edb_pkg::CNT_W-1:0]        scan_addr_ff;
   logic                             rd_vld_ff;
   logic                             rsp_valid_ff;

   // Payload registers.
   logic [edb_pkg::CHAR_W-1:0]       ch_ff;
   logic [edb_pkg::IDX_W-1:0]        last_id_ff;
   edb_pkg::key_type                 key_ff;
   edb_pkg::key_type                 key_rd_ff;
   edb_pkg::frame_type               frame_q_ff;
   logic [edb_pkg::IDX_W-1:0]        rd_idx_ff;
   logic                             res_valid_ff;
   logic [edb_pkg::IDX_W-1:0]        res_id_ff;
   logic                             res_new_ff;
   logic                             res_root_ff;
   edb_pkg::err_type                 res_err_ff;
   logic                             rsp_node_valid_ff;
   logic [edb_pkg::IDX_W-1:0]        rsp_id_ff;
   logic                             rsp_new_ff;
   logic                             rsp_root_ff;
   edb_pkg::err_type                 rsp_err_ff;

   // Combinational helpers.
   logic [edb_pkg::SDEP_W-1:0]       depth_m1;
   logic [edb_pkg::SIDX_W-1:0]       top_idx;
   logic [edb_pkg::SIDX_W-1:0]       push_idx;
   logic                             depth_nz;
   logic                             stack_full;
   edb_pkg::dec_type                 dec;
   edb_pkg::key_type                 leaf_key;
   edb_pkg::key_type                 close_key;
   logic                             scan_more;
   logic                             scan_issue;
   logic                             hit;
   logic                             miss;
   logic                             full;
   logic                             key_we;
   logic                             fr_we;
   logic [edb_pkg::SIDX_W-1:0]       fr_waddr;
   edb_pkg::frame_type               fr_wdata;

   // Stack pointers.
   assign depth_m1   = depth_ff - edb_pkg::SDEP_W'(1);
   assign top_idx    = depth_m1[edb_pkg::SIDX_W-1:0];
   assign push_idx   = depth_ff[edb_pkg::SIDX_W-1:0];
   assign depth_nz   = (depth_ff != '0);
   assign stack_full = (depth_ff == edb_pkg::SDEP_W'(edb_pkg::STACK_DEPTH));

   // Decode the character against the innermost open frame.
   always_comb begin
      if (depth_nz && (frame_q_ff.phase == edb_pkg::PH_OPER)) begin
         dec = edb_pkg::DEC_OPER;
      end else if (depth_nz && (frame_q_ff.phase == edb_pkg::PH_CLOSE)) begin
         dec = edb_pkg::DEC_CLOSE;
      end else if (ch_ff == edb_pkg::CH_OPEN) begin
         dec = edb_pkg::DEC_OPEN;
      end else begin
         dec = edb_pkg::DEC_LEAF;
      end
   end

   // Keys for a leaf and for a closing interior node.
   always_comb begin
      leaf_key       = '0;
      leaf_key.leaf  = 1'b1;
      leaf_key.oper  = edb_pkg::CH_SPACE;
      leaf_key.chr   = ch_ff;
      close_key      = '0;
      close_key.oper = frame_q_ff.oper;
      close_key.left = frame_q_ff.left;
      close_key.right = last_id_ff;
   end

   // Scan pipeline: one table read issued per cycle, its registered data compared in the next cycle.
   assign scan_more  = (scan_addr_ff < count_ff);
   assign hit        = rd_vld_ff && (key_rd_ff == key_ff);
   assign miss       = !rd_vld_ff && !scan_more;
   assign full       = (count_ff == edb_pkg::CNT_W'(edb_pkg::TABLE_DEPTH));
   assign scan_issue = cmd.scan && scan_more && !hit;
   assign key_we     = cmd.scan && miss && !full;

   // Status back to the controller.
   always_comb begin
      status            = '0;
      status.after_done = done_ff && !req_start_expr;
      status.lookup     = (dec == edb_pkg::DEC_CLOSE) || (dec == edb_pkg::DEC_LEAF);
      status.hit        = hit;
      status.miss       = miss;
      status.full       = full;
      status.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // Single write port of the frame stack.
   always_comb begin
      fr_we    = 1'b0;
      fr_waddr = top_idx;
      fr_wdata = frame_q_ff;
      if (cmd.decide && (dec == edb_pkg::DEC_OPER)) begin
         fr_we          = 1'b1;
         fr_wdata.oper  = ch_ff;
         fr_wdata.phase = edb_pkg::PH_RIGHT;
      end else if (cmd.decide && (dec == edb_pkg::DEC_OPEN) && !stack_full) begin
         fr_we          = 1'b1;
         fr_waddr       = push_idx;
         fr_wdata.left  = '0;
         fr_wdata.oper  = '0;
         fr_wdata.phase = edb_pkg::PH_LEFT;
      end else if (cmd.link && depth_nz) begin
         fr_we = 1'b1;
         if (frame_q_ff.phase == edb_pkg::PH_LEFT) begin
            fr_wdata.left  = res_id_ff;
            fr_wdata.phase = edb_pkg::PH_OPER;
         end else begin
            fr_wdata.phase = edb_pkg::PH_CLOSE;
         end
      end
   end

   // Frame stack memory with registered read of the top entry.
   always_ff @(posedge clock) begin
      if (fr_we) begin
         frame_mem[fr_waddr] <= fr_wdata;
      end
      if (cmd.frame_read) begin
         frame_q_ff <= frame_mem[top_idx];
      end
   end

   // Key table memory with registered read for the scan.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[edb_pkg::IDX_W-1:0]] <= key_ff;
      end
      if (scan_issue) begin
         key_rd_ff <= key_mem[scan_addr_ff[edb_pkg::IDX_W-1:0]];
      end
   end

   // Control state updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         depth_ff     <= '0;
         done_ff      <= 1'b0;
         scan_addr_ff <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_start_expr) begin
            count_ff <= '0;
            depth_ff <= '0;
            done_ff  <= 1'b0;
         end
         if (cmd.decide) begin
            scan_addr_ff <= '0;
            rd_vld_ff    <= 1'b0;
            if (dec == edb_pkg::DEC_OPEN) begin
               if (stack_full) begin
                  done_ff <= 1'b1;
               end else begin
                  depth_ff <= depth_ff + edb_pkg::SDEP_W'(1);
               end
            end else if (dec == edb_pkg::DEC_CLOSE) begin
               depth_ff <= depth_m1;
            end
         end
         if (cmd.scan) begin
            rd_vld_ff <= scan_issue;
            if (scan_issue) begin
               scan_addr_ff <= scan_addr_ff + edb_pkg::CNT_W'(1);
            end
            if (miss) begin
               if (full) begin
                  done_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + edb_pkg::CNT_W'(1);
               end
            end
         end
         if (cmd.link && !depth_nz) begin
            done_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload and result updates.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ch_ff        <= req_ch;
         res_valid_ff <= 1'b0;
         res_id_ff    <= '0;
         res_new_ff   <= 1'b0;
         res_root_ff  <= 1'b0;
         res_err_ff   <= status.after_done ? edb_pkg::ERR_AFTER_DONE : edb_pkg::ERR_NONE;
      end
      if (cmd.decide) begin
         key_ff <= (dec == edb_pkg::DEC_CLOSE) ? close_key : leaf_key;
         if ((dec == edb_pkg::DEC_OPEN) && stack_full) begin
            res_err_ff <= edb_pkg::ERR_STACK_OVERFLOW;
         end
      end
      if (scan_issue) begin
         rd_idx_ff <= scan_addr_ff[edb_pkg::IDX_W-1:0];
      end
      if (cmd.scan && hit) begin
         res_valid_ff <= 1'b1;
         res_id_ff    <= rd_idx_ff;
         res_new_ff   <= 1'b0;
         last_id_ff   <= rd_idx_ff;
      end
      if (key_we) begin
         res_valid_ff <= 1'b1;
         res_id_ff    <= count_ff[edb_pkg::IDX_W-1:0];
         res_new_ff   <= 1'b1;
         last_id_ff   <= count_ff[edb_pkg::IDX_W-1:0];
      end
      if (cmd.scan && miss && full) begin
         res_err_ff <= edb_pkg::ERR_TABLE_FULL;
      end
      if (cmd.link && !depth_nz) begin
         res_root_ff <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_node_valid_ff <= res_valid_ff;
         rsp_id_ff         <= res_id_ff;
         rsp_new_ff        <= res_new_ff;
         rsp_root_ff       <= res_root_ff;
         rsp_err_ff        <= res_err_ff;
      end
   end

   // Result word outputs.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_valid = rsp_node_valid_ff;
   assign rsp_node_id    = edb_pkg::NODE_ID_W'(rsp_id_ff);
   assign rsp_node_new   = rsp_new_ff;
   assign rsp_root_done  = rsp_root_ff;
   assign rsp_error_code = rsp_err_ff;

endmodule

>>> rtl/expression_dag_builder.sv
// An operator or '(' word passes frame fetch and decode to its result; a leaf or closing
// word also scans the node entries (up to 128) and updates the frame before its result.
// One word is taken at a time; the key table is scanned linearly on its single
// port, one read per cycle.
// Reset clears the entry count, stack depth, done flag and result valid; table and
// stack contents are left as they are and are never used before being written.
// ============================================================================
// Expression DAG builder
// Builds a shared node table for a fully parenthesized binary expression
// taken one character per word, returning each node id and whether it is new.
// ============================================================================
module expression_dag_builder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [edb_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          req_start_expr,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_node_valid,
   output logic [edb_pkg::NODE_ID_W-1:0] rsp_node_id,
   output logic                          rsp_node_new,
   output logic                          rsp_root_done,
   output logic [edb_pkg::ERR_W-1:0]     rsp_error_code
);

   edb_pkg::cmd_type    cmd;
   edb_pkg::status_type status;

   // Sequencer.
   edb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, stack and result register.
   edb_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_ch         (req_ch),
      .req_start_expr (req_start_expr),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_node_valid (rsp_node_valid),
      .rsp_node_id    (rsp_node_id),
      .rsp_node_new   (rsp_node_new),
      .rsp_root_done  (rsp_root_done),
      .rsp_error_code (rsp_error_code)
   );

endmodule

>>> rtl/edb_checker.sv
// ============================================================================
// Expression DAG builder checker
// Watches the top-level ports for consistency of the result words.
// ============================================================================
module edb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_node_valid,
   input logic [edb_pkg::NODE_ID_W-1:0] rsp_node_id,
   input logic                          rsp_node_new,
   input logic                          rsp_root_done,
   input logic [edb_pkg::ERR_W-1:0]     rsp_error_code
);

   // No result word is shown right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Without a lookup the node fields are zero.
   a_no_node_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_node_valid |->
         (rsp_node_id == '0) && !rsp_node_new && !rsp_root_done)
      else $error("node fields set without a lookup");

   // An error word carries no node.
   a_error_no_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != edb_pkg::ERR_NONE) |-> !rsp_node_valid)
      else $error("node reported with an error");

   // A finished root is a valid node.
   a_root_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_root_done |-> rsp_node_valid)
      else $error("root reported without a node");

endmodule

bind expression_dag_builder edb_checker u_edb_checker (.*);
